// ===== hdl/drld_pkg.sv =====
// Package: shared types, a constant and a helper function for the data run list decoder.
`default_nettype none

package drld_pkg;

    localparam int unsigned FIELD_MAX_BYTES = 8;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_OFFSET,
        PH_STOPPED
    } t_phase;

    typedef enum logic [1:0] {
        STOP_EXHAUSTED,
        STOP_ZERO_HEADER,
        STOP_BAD_HEADER,
        STOP_TRUNCATED
    } t_stop;

    typedef struct packed {
        logic        run_valid;
        logic [62:0] start_cluster;
        logic [63:0] cluster_count;
        logic        sparse_run;
        logic        list_end;
        logic        found_any;
        t_stop       stop_cause;
    } t_result;

    // Ones in every byte at or above the given field size.
    function automatic logic [63:0] sext_mask(input logic [3:0] size);
        logic [63:0] mask;
        mask = '0;
        for (int k = 0; k < FIELD_MAX_BYTES; k++) begin
            if (4'(k) >= size) begin
                mask[k*8 +: 8] = 8'hFF;
            end
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/drld_if.sv =====
// Interfaces: the byte input channel and the run result channel.
`default_nettype none

interface drld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface drld_out_if;
    logic        valid;
    logic        ready;
    logic        run_valid;
    logic [62:0] start_cluster;
    logic [63:0] cluster_count;
    logic        sparse_run;
    logic        list_end;
    logic        found_any;
    logic [1:0]  stop_cause;

    modport source (
        output valid, output run_valid, output start_cluster, output cluster_count,
        output sparse_run, output list_end, output found_any, output stop_cause,
        input ready
    );
    modport sink (
        input valid, input run_valid, input start_cluster, input cluster_count,
        input sparse_run, input list_end, input found_any, input stop_cause,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/drld_parse.sv =====
// Run list parser: parse state registers and the per-byte next-state and result logic.
`default_nettype none

module drld_parse
    import drld_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_has_result,
    output t_result         o_result
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_len_size, n_len_size;
    logic [3:0]  r_off_size, n_off_size;
    logic [3:0]  r_index, n_index;
    logic [63:0] r_len_acc, n_len_acc;
    logic [63:0] r_off_acc, n_off_acc;
    logic [63:0] r_position, n_position;
    logic        r_run_seen, n_run_seen;
    t_stop       r_stop, n_stop;

    logic [3:0]  hdr_len;
    logic [3:0]  hdr_off;
    logic [3:0]  index_inc;
    logic [63:0] byte_shifted;
    logic        finish;
    logic        emit;

    assign hdr_len      = i_data_byte[3:0];
    assign hdr_off      = i_data_byte[7:4];
    assign index_inc    = r_index + 4'd1;
    assign byte_shifted = {56'd0, i_data_byte} << {r_index[2:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_len_size <= '0;
            r_off_size <= '0;
            r_index    <= '0;
            r_len_acc  <= '0;
            r_off_acc  <= '0;
            r_position <= '0;
            r_run_seen <= 1'b0;
            r_stop     <= STOP_EXHAUSTED;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_len_size <= n_len_size;
            r_off_size <= n_off_size;
            r_index    <= n_index;
            r_len_acc  <= n_len_acc;
            r_off_acc  <= n_off_acc;
            r_position <= n_position;
            r_run_seen <= n_run_seen;
            r_stop     <= n_stop;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_len_size = r_len_size;
        n_off_size = r_off_size;
        n_index    = r_index;
        n_len_acc  = r_len_acc;
        n_off_acc  = r_off_acc;
        n_position = r_position;
        n_run_seen = r_run_seen;
        n_stop     = r_stop;
        finish     = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                priority if (i_data_byte == 8'd0) begin
                    n_phase = PH_STOPPED;
                    n_stop  = STOP_ZERO_HEADER;
                end else if (hdr_len == 4'd0 || hdr_len > 4'(FIELD_MAX_BYTES)
                             || hdr_off > 4'(FIELD_MAX_BYTES)) begin
                    n_phase = PH_STOPPED;
                    n_stop  = STOP_BAD_HEADER;
                end else begin
                    n_len_size = hdr_len;
                    n_off_size = hdr_off;
                    n_index    = '0;
                    n_len_acc  = '0;
                    n_off_acc  = '0;
                    n_phase    = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                n_len_acc = r_len_acc | byte_shifted;
                n_index   = index_inc;
                if (index_inc >= r_len_size) begin
                    if (r_off_size == 4'd0) begin
                        finish = 1'b1;
                    end else begin
                        n_phase = PH_OFFSET;
                        n_index = '0;
                    end
                end
            end
            PH_OFFSET: begin
                n_off_acc = r_off_acc | byte_shifted;
                n_index   = index_inc;
                if (index_inc >= r_off_size) begin
                    if (i_data_byte[7]) begin
                        n_off_acc = n_off_acc | sext_mask(r_off_size);
                    end
                    n_position = r_position + n_off_acc;
                    finish     = 1'b1;
                end
            end
            PH_STOPPED: begin
            end
        endcase

        emit = finish && (n_len_acc != 64'd0) && !n_position[63];
        if (finish) begin
            n_phase = PH_HEADER;
            n_index = '0;
        end
        if (emit) begin
            n_run_seen = 1'b1;
        end

        o_result               = '0;
        o_result.run_valid     = emit;
        o_result.start_cluster = emit ? n_position[62:0] : 63'd0;
        o_result.cluster_count = emit ? n_len_acc : 64'd0;
        o_result.sparse_run    = emit && (r_off_size == 4'd0);
        o_result.stop_cause    = STOP_EXHAUSTED;
        o_has_result           = emit || i_last_byte;

        if (i_last_byte) begin
            o_result.list_end   = 1'b1;
            o_result.found_any  = n_run_seen;
            o_result.stop_cause = (n_phase == PH_LENGTH || n_phase == PH_OFFSET)
                                  ? STOP_TRUNCATED : n_stop;
            n_phase    = PH_HEADER;
            n_len_size = '0;
            n_off_size = '0;
            n_index    = '0;
            n_len_acc  = '0;
            n_off_acc  = '0;
            n_position = '0;
            n_run_seen = 1'b0;
            n_stop     = STOP_EXHAUSTED;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/data_run_list_decoder_core.sv =====
// Top level of the data run list decoder: byte parser and registered result word.
//
//  Channel  Direction  Word contents
//  i_in     sink       data_byte[7:0], last_byte
//  o_out    source     run_valid, start_cluster[62:0], cluster_count[63:0],
//                      sparse_run, list_end, found_any, stop_cause[1:0]
//
// One byte is accepted every cycle while the output register is empty or the sink
// is ready; its result word, if any, appears in the output register on the next cycle.
// The rate is set by the parse step: a byte shift-in and one 64-bit add.
// The synchronous reset returns the parser to the header phase and empties
// the output register. A held output word stalls the input only when the
// sink is not ready in that cycle.
`default_nettype none

module data_run_list_decoder_core
    import drld_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    drld_in_if.sink    i_in,
    drld_out_if.source o_out
);

    logic    accept;
    logic    has_result;
    t_result step_result;
    t_result r_out;
    logic    r_out_valid;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    drld_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (accept),
        .i_data_byte  (i_in.data_byte),
        .i_last_byte  (i_in.last_byte),
        .o_has_result (has_result),
        .o_result     (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && has_result) begin
            r_out <= step_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.run_valid     = r_out.run_valid;
    assign o_out.start_cluster = r_out.start_cluster;
    assign o_out.cluster_count = r_out.cluster_count;
    assign o_out.sparse_run    = r_out.sparse_run;
    assign o_out.list_end      = r_out.list_end;
    assign o_out.found_any     = r_out.found_any;
    assign o_out.stop_cause    = r_out.stop_cause;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("Input accepted while the output word is stalled.");

    a_word_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.run_valid || o_out.list_end))
        else $error("Output word carries neither a run nor a list end.");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.run_valid) |-> (o_out.cluster_count != 64'd0))
        else $error("Run emitted with a zero cluster count.");

    a_no_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.run_valid) |->
        (o_out.start_cluster == 63'd0 && o_out.cluster_count == 64'd0 && !o_out.sparse_run))
        else $error("Run fields are not clear on a word without a run.");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.list_end) |->
        (!o_out.found_any && o_out.stop_cause == 2'd0))
        else $error("List end fields set on a word that does not end the list.");

endmodule

`default_nettype wire
